@@ hw/rtl/api_frame_deframer_defines.svh @@
// Assertion macros shared by the checker of the frame deframer.
`ifndef API_FRAME_DEFRAMER_DEFINES_SVH
`define API_FRAME_DEFRAMER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/afd_pkg.sv @@
`default_nettype none

package afd_pkg;

  localparam logic [7:0] START_BYTE = 8'h7E;
  localparam logic [7:0] SUM_BASE   = 8'hFF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] byte_offset;
    logic       is_end;
    logic       checksum_ok;
    logic [7:0] frame_type;
    logic [7:0] frame_length;
  } res_t;

endpackage

`default_nettype wire

@@ hw/rtl/api_frame_deframer.sv @@
// A result word is registered in the output buffer before it is shown. Throughput: one
// byte per cycle while the buffer has room; a two-word output buffer keeps the input
// ready while a single word waits downstream. Start, length and idle bytes give no word.
// Reset (synchronous, active low) returns the parser to waiting for a start byte
// and empties the output buffer.
`default_nettype none

module api_frame_deframer import afd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_data_byte,
  output logic [7:0]      out_byte_offset,
  output logic            out_is_end,
  output logic            out_checksum_ok,
  output logic [7:0]      out_frame_type,
  output logic [7:0]      out_frame_length
);

  logic take;
  logic res_valid;
  logic can_push;
  res_t res;
  res_t out_word;

  assign in_ready = can_push;
  assign take     = in_valid && in_ready;

  afd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .rx_byte   (in_rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  afd_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (take && res_valid),
    .push_word (res),
    .can_push  (can_push),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  assign out_data_byte    = out_word.data_byte;
  assign out_byte_offset  = out_word.byte_offset;
  assign out_is_end       = out_word.is_end;
  assign out_checksum_ok  = out_word.checksum_ok;
  assign out_frame_type   = out_word.frame_type;
  assign out_frame_length = out_word.frame_length;

endmodule

`default_nettype wire

@@ hw/rtl/afd_parser.sv @@
`default_nettype none

module afd_parser import afd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       take,
  input  wire logic [7:0] rx_byte,
  output logic            res_valid,
  output res_t            res
);

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_LEN_HI = 2'd1;
  localparam logic [1:0] PH_LEN_LO = 2'd2;
  localparam logic [1:0] PH_BODY   = 2'd3;

  logic [1:0] phase_r, phase_nxt;
  logic [8:0] remain_r, remain_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] length_r, length_nxt;
  logic [7:0] offset_r, offset_nxt;
  logic [7:0] type_r, type_nxt;
  logic       in_body;
  logic [7:0] expect_sum;

  assign in_body    = (remain_r > 9'd1);
  assign expect_sum = SUM_BASE - sum_r;
  assign res_valid  = (phase_r == PH_BODY);

  always_comb begin
    res = '0;
    res.data_byte = rx_byte;
    if (in_body) begin
      res.byte_offset = offset_r;
    end else begin
      res.is_end       = 1'b1;
      res.checksum_ok  = (expect_sum == rx_byte);
      res.frame_type   = type_r;
      res.frame_length = length_r;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    remain_nxt = remain_r;
    sum_nxt    = sum_r;
    length_nxt = length_r;
    offset_nxt = offset_r;
    type_nxt   = type_r;
    case (phase_r)
      PH_IDLE: begin
        if (rx_byte == START_BYTE) begin
          phase_nxt  = PH_LEN_HI;
          remain_nxt = '0;
          sum_nxt    = '0;
          length_nxt = '0;
          offset_nxt = '0;
          type_nxt   = '0;
        end
      end
      PH_LEN_HI: begin
        phase_nxt = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        length_nxt = rx_byte;
        remain_nxt = {1'b0, rx_byte} + 9'd1;
        phase_nxt  = PH_BODY;
      end
      PH_BODY: begin
        if (in_body) begin
          if (offset_r == 8'd0) begin
            type_nxt = rx_byte;
          end
          sum_nxt    = sum_r + rx_byte;
          offset_nxt = offset_r + 8'd1;
          remain_nxt = remain_r - 9'd1;
        end else begin
          phase_nxt  = PH_IDLE;
          remain_nxt = '0;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      remain_r <= '0;
      sum_r    <= '0;
      length_r <= '0;
      offset_r <= '0;
      type_r   <= '0;
    end else if (take) begin
      phase_r  <= phase_nxt;
      remain_r <= remain_nxt;
      sum_r    <= sum_nxt;
      length_r <= length_nxt;
      offset_r <= offset_nxt;
      type_r   <= type_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/afd_skid.sv @@
`default_nettype none

module afd_skid import afd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire res_t push_word,
  output logic      can_push,
  output logic      out_valid,
  input  wire logic out_ready,
  output res_t      out_word
);

  logic main_v_r, main_v_nxt;
  logic skid_v_r, skid_v_nxt;
  res_t main_r, main_nxt;
  res_t skid_r, skid_nxt;
  logic pop;

  assign can_push  = !skid_v_r;
  assign out_valid = main_v_r;
  assign out_word  = main_r;
  assign pop       = main_v_r && out_ready;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    if (pop) begin
      if (skid_v_r) begin
        main_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end else if (push) begin
        main_nxt = push_word;
      end else begin
        main_v_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_v_r) begin
        main_nxt   = push_word;
        main_v_nxt = 1'b1;
      end else begin
        skid_nxt   = push_word;
        skid_v_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

`default_nettype wire

@@ hw/rtl/afd_checker.sv @@
`default_nettype none
`include "api_frame_deframer_defines.svh"

module afd_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [7:0] in_rx_byte,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_data_byte,
  input wire logic [7:0] out_byte_offset,
  input wire logic       out_is_end,
  input wire logic       out_checksum_ok,
  input wire logic [7:0] out_frame_type,
  input wire logic [7:0] out_frame_length
);

  `AFD_ASSERT_NOW(a_end_offset_zero, out_valid && out_is_end, out_byte_offset == 8'd0,
    "end word carries a non-zero offset")

  `AFD_ASSERT_NOW(a_content_clean,
    out_valid && !out_is_end,
    !out_checksum_ok && (out_frame_type == 8'd0) && (out_frame_length == 8'd0),
    "content word carries frame summary fields")

  `AFD_ASSERT_NOW(a_empty_frame_type,
    out_valid && out_is_end && (out_frame_length == 8'd0),
    out_frame_type == 8'd0,
    "empty frame reports a frame type")

  `AFD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_data_byte) && $stable(out_is_end),
    "stalled output word changed")

  `AFD_ASSERT_NEXT(a_in_hold, in_valid && !in_ready,
    in_valid && $stable(in_rx_byte),
    "stalled input word changed")

endmodule

bind api_frame_deframer afd_checker u_afd_checker (.*);

`default_nettype wire
